// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/lsm_pkg.sv
// Types and constants of the line substring matcher.
package lsm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_LINE    = 1024;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int PLEN_W      = 5;
  localparam int LEN_W       = 10;
  localparam int NUM_W       = 16;
  localparam int REG_W       = 64;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]       NEWLINE_BYTE = 8'd10;
  localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(MAX_LINE - 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [LEN_W-1:0] length;
    logic             matched;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage

// File: hw/rtl/lsm_front.sv
// Front end: pattern registers, line window compare and per-line counters.
module lsm_front
  import lsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [REG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  input  fifo_st_t              fifo_st_i,
  output logic                  push_o,
  output result_t               push_data_o
);

  logic [REG_W-1:0]  pat_lo_q, pat_hi_q;
  logic [PLEN_W-1:0] plen_q;
  logic [MAX_PATTERN-1:0][7:0] pat;
  logic [PLEN_W-1:0] plen_eff;

  logic [WIN_DEPTH-1:0][7:0] win_q;
  logic [IDX_W-1:0]  fill_q, fill_d;
  logic              found_q, found_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [NUM_W-1:0]  line_q, line_d;

  logic [MAX_PATTERN-1:0][7:0] cur;
  logic match;
  logic accept, is_nl, line_end;
  logic found_new;
  logic [LEN_W-1:0] len_new;

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat[k] = (k < 8) ? pat_lo_q[8*(k%8) +: 8] : pat_hi_q[8*(k%8) +: 8];
    end
  end

  assign plen_eff = (plen_q > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : plen_q;

  always_comb begin
    cur[0] = in_byte_i;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      cur[k] = win_q[k-1];
    end
  end

  // Lane k holds the byte k places back; it must equal pattern byte len-1-k.
  always_comb begin
    logic [PLEN_W-1:0] diff;
    match = (plen_eff != '0) && (PLEN_W'(fill_q) >= (plen_eff - PLEN_W'(1)));
    for (int k = 0; k < MAX_PATTERN; k++) begin
      diff = plen_eff - PLEN_W'(k) - PLEN_W'(1);
      if ((PLEN_W'(k) < plen_eff) && (cur[k] != pat[diff[IDX_W-1:0]])) begin
        match = 1'b0;
      end
    end
  end

  assign in_ready_o = !fifo_st_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign is_nl      = (in_byte_i == NEWLINE_BYTE);
  assign line_end   = is_nl || in_last_i;

  assign found_new = found_q || (!is_nl && match);
  assign len_new   = (is_nl || (len_q == LEN_MAX)) ? len_q : len_q + LEN_W'(1);

  assign push_o             = accept && line_end;
  assign push_data_o.matched = found_new;
  assign push_data_o.length  = len_new;
  assign push_data_o.number  = line_q;

  always_comb begin
    fill_d  = fill_q;
    found_d = found_q;
    len_d   = len_q;
    line_d  = line_q;
    if (accept) begin
      if (line_end) begin
        fill_d  = '0;
        found_d = 1'b0;
        len_d   = '0;
        line_d  = in_last_i ? '0 : line_q + NUM_W'(1);
      end else begin
        fill_d  = (fill_q == IDX_W'(WIN_DEPTH)) ? fill_q : fill_q + IDX_W'(1);
        found_d = found_new;
        len_d   = len_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      plen_q   <= PLEN_W'(1);
      fill_q   <= '0;
      found_q  <= 1'b0;
      len_q    <= '0;
      line_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          REG_PAT_LO:  pat_lo_q <= cfg_wdata_i;
          REG_PAT_HI:  pat_hi_q <= cfg_wdata_i;
          REG_PAT_LEN: plen_q   <= cfg_wdata_i[PLEN_W-1:0];
          default: ;
        endcase
      end
      fill_q  <= fill_d;
      found_q <= found_d;
      len_q   <= len_d;
      line_q  <= line_d;
    end
  end

  // Window contents past fill_q are never compared.
  always_ff @(posedge clk_i) begin
    if (accept && !is_nl) begin
      win_q <= {win_q[WIN_DEPTH-2:0], in_byte_i};
    end
  end

endmodule

// File: hw/rtl/lsm_fifo.sv
// Result queue between the front end and the output stage.
module lsm_fifo
  import lsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  result_t  push_data_i,
  input  logic     pop_i,
  output result_t  pop_data_o,
  output fifo_st_t st_o
);

  result_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign st_o.full   = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign st_o.empty  = (cnt_q == '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: hw/rtl/lsm_out.sv
// Output stage: registered result toward the downstream stream.
module lsm_out
  import lsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fifo_st_t fifo_st_i,
  input  result_t  fifo_data_i,
  output logic     pop_o,
  output logic     out_valid_o,
  output result_t  out_data_o,
  input  logic     out_ready_i
);

  logic    valid_q;
  result_t data_q;

  assign pop_o       = !fifo_st_i.empty && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= fifo_data_i;
    end
  end

endmodule

// File: hw/rtl/line_substring_match.sv
// Top level of the per-line substring matcher.
//
//   channel   dir  transfer when              payload
//   s_axis    in   tvalid & tready            text byte, tlast = end of text
//   m_axis    out  tvalid & tready            one result per finished line
//   cfg       in   cfg_we_i                   pattern low, pattern high, length
//
// One text byte per cycle while s_axis_tready is high; the whole window compare happens in the accepting cycle.
// A result is written into the queue, then into the output register, before it shows on m_axis.
// Four results queue between front end and output register; s_axis_tready
// drops only while that queue is full.
// Reset clears all control state; no clearing pass.
`include "assert_macros.svh"

module line_substring_match
  import lsm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [REG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] text_byte
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] line_matched, [10:1] line_length, [26:11] line_number, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  fifo_st_t fifo_st;
  logic     push, pop;
  result_t  push_data, fifo_data, out_data;

  lsm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata[7:0]),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .fifo_st_i   (fifo_st),
    .push_o      (push),
    .push_data_o (push_data)
  );

  lsm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (fifo_data),
    .st_o        (fifo_st)
  );

  lsm_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_st_i   (fifo_st),
    .fifo_data_i (fifo_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_data);

  `ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push, !fifo_st.full)
  `ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop, !fifo_st.empty)
  `ASSERT_IMPL(a_last_pushes, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, push)
  `ASSERT_NEXT(a_pop_shows, clk_i, rst_ni, pop, m_axis_tvalid)

endmodule
